// ===== rtl/core/srt_pkg.sv =====
// shared types and constants of the stream rank tracker
package srt_pkg;

	// default sizing handed to the top level parameters
	localparam int DEF_ENTRIES    = 64;
	localparam int DEF_COUNT_BITS = 16;

	// fixed field widths
	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 23;
	localparam int STATUS_W = 2;

	// largest reportable rank, results above it saturate
	localparam logic [RANK_W-1:0] RANK_MAX = 23'h3F_FFFF;

	// item modes
	localparam logic MODE_TRACK = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} srt_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
		logic out_load;
	} srt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic hit;
		logic scan_end;
	} srt_sts_t;

endpackage

// ===== rtl/core/stream_rank_tracker_unit.sv =====
// top level of the stream rank tracker
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------
//   input    | in_valid / in_ready   | mode, value
//   output   | out_valid / out_ready | rank, status
//
// an item scans the stored entries in turn, fill being the number of stored
// entries (at most ENTRIES); a track that finds its value stops early.
// the scan speed is set by the single read port of the table ram, one entry per cycle.
// reset clears the fill count, so the table is empty at once with no clearing pass.
// a finished result waits in the output register while the next item is taken;
// the block holds in its last state only when that register is still full.
module stream_rank_tracker_unit
	import srt_pkg::*;
#(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [RANK_W-1:0]  rank,
	output logic [STATUS_W-1:0]       status
);

	srt_cmd_t cmd;
	srt_sts_t sts;

	// controller
	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	srt_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.mode   (mode),
		.value  (value),
		.rank   (rank),
		.status (status)
	);

	// one item at a time: no new transfer right after an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");

	// a flagged track result never carries a rank
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STATUS_OK)) |-> (rank == '0))
		else $error("nonzero rank with nonzero status");

	// only defined status codes leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK || status == STATUS_FULL || status == STATUS_SAT))
		else $error("undefined status code");

endmodule

// ===== rtl/core/srt_ram.sv =====
// generic simple dual port ram with registered read
module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/srt_ctrl.sv =====
// controller state machine of the stream rank tracker
module srt_ctrl
	import srt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output srt_cmd_t cmd,
	input  srt_sts_t sts
);

	srt_state_t state_q;
	srt_state_t state_d;
	logic       out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_DONE;
				end else if (sts.scan_end) begin
					cmd.commit = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/srt_dp.sv =====
// datapath of the stream rank tracker: table ram, scan counter, sum and result registers
module srt_dp
	import srt_pkg::*;
#(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  srt_cmd_t                   cmd,
	output srt_sts_t                   sts,
	input  logic                       mode,
	input  logic signed [VALUE_W-1:0]  value,
	output logic signed [RANK_W-1:0]   rank,
	output logic [STATUS_W-1:0]        status
);

	localparam int ADDR_W = $clog2(ENTRIES);
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int SUM_W  = COUNT_BITS + FILL_W;
	localparam int CMP_W  = (SUM_W > RANK_W) ? SUM_W : RANK_W;
	localparam int RAM_W  = VALUE_W + COUNT_BITS;

	logic [FILL_W-1:0]     idx_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  rd_vld_s1;
	logic [ADDR_W-1:0]     rd_addr_s1;
	logic                  mode_q;
	logic [VALUE_W-1:0]    value_q;
	logic [SUM_W-1:0]      sum_q;
	logic [RANK_W-1:0]     res_rank_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [RANK_W-1:0]     rank_q;
	logic [STATUS_W-1:0]   status_q;

	logic [RAM_W-1:0]      rd_data;
	logic [VALUE_W-1:0]    rd_value;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  issue;
	logic                  hit;
	logic                  at_or_below;
	logic                  full;
	logic                  count_max;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [RAM_W-1:0]      wdata;
	logic [CMP_W-1:0]      sum_m1;
	logic [RANK_W-1:0]     rank_calc;

	// entry table: value in the upper bits, count in the lower bits
	srt_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	assign rd_value = rd_data[RAM_W-1 -: VALUE_W];
	assign rd_count = rd_data[COUNT_BITS-1:0];

	// scan and compare, entries below the fill count are the valid ones
	assign issue       = cmd.scan && (idx_q < fill_q);
	assign hit         = cmd.scan && rd_vld_s1 && (mode_q == MODE_TRACK) && (rd_value == value_q);
	assign at_or_below = $signed(rd_value) <= $signed(value_q);
	assign full        = (fill_q == FILL_W'(ENTRIES));
	assign count_max   = &rd_count;

	assign sts.hit      = hit;
	assign sts.scan_end = (idx_q == fill_q) && !rd_vld_s1;

	// table write: count bump on a hit, or a new entry at the fill point
	always_comb begin
		we    = 1'b0;
		waddr = rd_addr_s1;
		wdata = {rd_value, rd_count + COUNT_BITS'(1)};
		if (hit) begin
			we = !count_max;
		end else if (cmd.commit && (mode_q == MODE_TRACK) && !full) begin
			we    = 1'b1;
			waddr = fill_q[ADDR_W-1:0];
			wdata = {value_q, COUNT_BITS'(1)};
		end
	end

	// rank from the sum: minus one, -1 when empty, saturated at the top
	always_comb begin
		sum_m1 = CMP_W'(sum_q) - CMP_W'(1);
		if (sum_q == '0) begin
			rank_calc = '1;
		end else if (sum_m1 > CMP_W'(RANK_MAX)) begin
			rank_calc = RANK_MAX;
		end else begin
			rank_calc = sum_m1[RANK_W-1:0];
		end
	end

	// scan counter, read valid and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			fill_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + FILL_W'(1);
				end
			end
			if (cmd.commit && (mode_q == MODE_TRACK) && !full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// item capture, address pipe and count sum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			value_q <= value;
			sum_q   <= '0;
		end else if (cmd.scan && rd_vld_s1 && (mode_q == MODE_QUERY) && at_or_below) begin
			sum_q <= sum_q + SUM_W'(rd_count);
		end
		if (issue) begin
			rd_addr_s1 <= idx_q[ADDR_W-1:0];
		end
	end

	// result and output registers
	always_ff @(posedge clk) begin
		if (hit) begin
			res_rank_q   <= '0;
			res_status_q <= count_max ? STATUS_SAT : STATUS_OK;
		end else if (cmd.commit) begin
			if (mode_q == MODE_TRACK) begin
				res_rank_q   <= '0;
				res_status_q <= full ? STATUS_FULL : STATUS_OK;
			end else begin
				res_rank_q   <= rank_calc;
				res_status_q <= STATUS_OK;
			end
		end
		if (cmd.out_load) begin
			rank_q   <= res_rank_q;
			status_q <= res_status_q;
		end
	end

	assign rank   = rank_q;
	assign status = status_q;

endmodule
